### hw/rtl/layer_pixel_over_blend_assert.svh
// assertion macros shared by the layer pixel over blend rtl
// expects the including module to have clk and rst_n in scope
`ifndef LAYER_PIXEL_OVER_BLEND_ASSERT_SVH
`define LAYER_PIXEL_OVER_BLEND_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define LPOB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define LPOB_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/lpob_pkg.sv
// shared widths, constants, types and constant-divide helpers for the over blend
// no dependencies
package lpob_pkg;

    localparam int CH_W       = 8;
    localparam int PIX_W      = 64;
    localparam int OPAC_W     = 7;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 7;
    localparam int PROD_W     = 15;
    localparam int DEN_W      = 16;
    localparam int NUM_W      = 24;
    localparam int QUO_W      = 8;
    localparam int DIV_BPS    = 2;
    localparam int DIV_STAGES = QUO_W / DIV_BPS;

    // request edge to result edge: four front stages, the divider, one output register
    localparam int PIPE_LATENCY = 5 + DIV_STAGES;

    localparam logic [CFG_IDX_W-1:0] REG_LAYER_OPACITY  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BYTE_ORDER_BIG = 4'd1;

    localparam logic [OPAC_W-1:0] OPAC_FULL  = 7'd100;
    localparam logic [CH_W-1:0]   CH_MAX     = 8'd255;
    localparam logic [DEN_W-1:0]  ROUND_255  = 16'd127;

    // floor(y / 100) for y below 25600, where the quotient fits in CH_W bits
    localparam logic [PROD_W-1:0] RECIP100       = 15'd20972;
    localparam int                RECIP100_SHIFT = 21;
    // floor(x / 255) for x below 65280, where the quotient fits in CH_W bits
    localparam logic [DEN_W-1:0]  RECIP255       = 16'd32897;
    localparam int                RECIP255_SHIFT = 23;

    typedef enum logic [1:0] {
        MODE_KEEP,
        MODE_OPAQUE,
        MODE_CLEAR,
        MODE_OVER
    } lpob_mode_t;

    typedef struct packed {
        lpob_mode_t      mode;
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] alpha;
    } lpob_side_t;

    function automatic logic [CH_W-1:0] div100(input logic [PROD_W-1:0] y);
        logic [2*PROD_W-1:0] p;
        p = (2*PROD_W)'(y) * (2*PROD_W)'(RECIP100);
        return p[RECIP100_SHIFT+CH_W-1:RECIP100_SHIFT];
    endfunction

    function automatic logic [CH_W-1:0] div255(input logic [DEN_W-1:0] x);
        logic [2*DEN_W-1:0] p;
        p = (2*DEN_W)'(x) * (2*DEN_W)'(RECIP255);
        return p[RECIP255_SHIFT+CH_W-1:RECIP255_SHIFT];
    endfunction

endpackage

### hw/rtl/lpob_div_pipe.sv
// pipelined restoring divider, two quotient bits per register stage
// depends on lpob_pkg; quotient must fit in QUO_W bits
module lpob_div_pipe
    import lpob_pkg::*;
(
    input  logic             clk,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [QUO_W-1:0] quo
);

    logic [NUM_W-1:0] rem_reg [DIV_STAGES-1];
    logic [DEN_W-1:0] den_reg [DIV_STAGES-1];
    logic [QUO_W-1:0] quo_reg [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_stage
        logic [NUM_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [QUO_W-1:0] quo_in;
        logic [NUM_W-1:0] rem_next;
        logic [QUO_W-1:0] quo_next;

        if (s == 0)
        begin : g_head
            assign rem_in = num;
            assign den_in = den;
            assign quo_in = '0;
        end
        else
        begin : g_tail
            assign rem_in = rem_reg[s-1];
            assign den_in = den_reg[s-1];
            assign quo_in = quo_reg[s-1];
        end

        // quotient bits shift in from the right, msb first
        always_comb
        begin
            rem_next = rem_in;
            quo_next = quo_in;
            for (int k = 0; k < DIV_BPS; k++)
            begin
                if (rem_next >= (NUM_W'(den_in) << (QUO_W - 1 - s * DIV_BPS - k)))
                begin
                    rem_next = rem_next - (NUM_W'(den_in) << (QUO_W - 1 - s * DIV_BPS - k));
                    quo_next = {quo_next[QUO_W-2:0], 1'b1};
                end
                else
                begin
                    quo_next = {quo_next[QUO_W-2:0], 1'b0};
                end
            end
        end

        if (s < DIV_STAGES - 1)
        begin : g_fwd
            always_ff @(posedge clk)
            begin
                rem_reg[s] <= rem_next;
                den_reg[s] <= den_in;
            end
        end

        always_ff @(posedge clk)
        begin
            quo_reg[s] <= quo_next;
        end
    end

    assign quo = quo_reg[DIV_STAGES-1];

endmodule

### hw/rtl/layer_pixel_over_blend.sv
// layer_pixel_over_blend: composites one layer pixel over one destination pixel
// depends on lpob_pkg, lpob_div_pipe and layer_pixel_over_blend_assert.svh
//
// usage
//   request channel: pixel_word and dest_* are taken at a rising edge with start
//   high and busy low. busy stays low, so a request can be issued every cycle.
//   result channel: out_* are valid for one cycle while strobe is high; the
//   receiver cannot stall, so nothing is ever held back.
//   config channel: cfg_index/cfg_data written when cfg_valid and cfg_ready are
//   high; cfg_ready is always high. index 0 is layer_opacity (percent), index 1
//   is byte_order_big. other indexes are ignored.
// pipeline and throughput
//   strobe rises once the request has passed four front stages, a four
//   stage divider taking two quotient bits per stage and one output register.
//   one pixel per cycle sustained: every stage is a plain register with a
//   valid bit and the three colour dividers are fully pipelined.
// reset
//   rst_n clears all valid bits and sets opacity 100, little-endian order.
//   requests in flight at reset are dropped.
module layer_pixel_over_blend
    import lpob_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [PIX_W-1:0]      pixel_word,
    input  logic [CH_W-1:0]       dest_red,
    input  logic [CH_W-1:0]       dest_green,
    input  logic [CH_W-1:0]       dest_blue,
    input  logic [CH_W-1:0]       dest_alpha,
    output logic                  strobe,
    output logic [CH_W-1:0]       out_red,
    output logic [CH_W-1:0]       out_green,
    output logic [CH_W-1:0]       out_blue,
    output logic [CH_W-1:0]       out_alpha,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic accept;

    // config registers
    logic [OPAC_W-1:0] opac_reg;
    logic              big_reg;

    // stage 1: picked bytes and opacity product
    logic              s1_vld_reg;
    logic [CH_W-1:0]   s1_sr_reg, s1_sg_reg, s1_sb_reg, s1_sa_reg;
    logic [CH_W-1:0]   s1_dr_reg, s1_dg_reg, s1_db_reg, s1_da_reg;
    logic [PROD_W-1:0] s1_prod_reg;
    logic              s1_scale_reg;
    logic [CH_W-1:0]   s1_sr_next, s1_sg_next, s1_sb_next, s1_sa_next;
    logic [PROD_W-1:0] s1_prod_next;

    // stage 2: scaled alpha
    logic              s2_vld_reg;
    logic [CH_W-1:0]   s2_sr_reg, s2_sg_reg, s2_sb_reg, s2_alpha_reg;
    logic [CH_W-1:0]   s2_dr_reg, s2_dg_reg, s2_db_reg, s2_da_reg;
    logic [CH_W-1:0]   s2_alpha_next;

    // stage 3: partial products, den, mode
    logic              s3_vld_reg;
    lpob_mode_t        s3_mode_reg, s3_mode_next;
    logic [DEN_W-1:0]  s3_den_reg, s3_den_next;
    logic [DEN_W-1:0]  s3_sa_r_reg, s3_sa_g_reg, s3_sa_b_reg;
    logic [DEN_W-1:0]  s3_dinv_r_reg, s3_dinv_g_reg, s3_dinv_b_reg;
    logic [CH_W-1:0]   s3_sr_reg, s3_sg_reg, s3_sb_reg, s3_alpha_reg;
    logic [CH_W-1:0]   s3_dr_reg, s3_dg_reg, s3_db_reg, s3_da_reg;
    logic [CH_W-1:0]   s3_inv;
    logic [DEN_W-1:0]  s3_src;

    // stage 4: numerators
    logic              s4_vld_reg;
    lpob_mode_t        s4_mode_reg;
    logic [DEN_W-1:0]  s4_den_reg;
    logic [NUM_W-1:0]  s4_nov_r_reg, s4_nov_g_reg, s4_nov_b_reg;
    logic [NUM_W-1:0]  s4_nov_r_next, s4_nov_g_next, s4_nov_b_next;
    logic [DEN_W-1:0]  s4_nop_r_reg, s4_nop_g_reg, s4_nop_b_reg;
    logic [DEN_W-1:0]  s4_anum_reg;
    logic [CH_W-1:0]   s4_sr_reg, s4_sg_reg, s4_sb_reg, s4_alpha_reg;
    logic [CH_W-1:0]   s4_dr_reg, s4_dg_reg, s4_db_reg, s4_da_reg;

    // side band alongside the divider
    logic              side_vld_reg [DIV_STAGES];
    lpob_side_t        side_reg [DIV_STAGES];
    lpob_side_t        side_next;

    logic [QUO_W-1:0]  quo_r, quo_g, quo_b;

    // output register
    logic              strobe_reg;
    logic [CH_W-1:0]   out_r_reg, out_g_reg, out_b_reg, out_a_reg;
    logic [CH_W-1:0]   out_r_next, out_g_next, out_b_next;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            opac_reg <= OPAC_FULL;
            big_reg  <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_LAYER_OPACITY:  opac_reg <= cfg_data[OPAC_W-1:0];
                REG_BYTE_ORDER_BIG: big_reg  <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    // stage 1: top byte of each 16-bit channel
    always_comb
    begin
        if (big_reg)
        begin
            s1_sr_next = pixel_word[7:0];
            s1_sg_next = pixel_word[23:16];
            s1_sb_next = pixel_word[39:32];
            s1_sa_next = pixel_word[55:48];
        end
        else
        begin
            s1_sr_next = pixel_word[63:56];
            s1_sg_next = pixel_word[47:40];
            s1_sb_next = pixel_word[31:24];
            s1_sa_next = pixel_word[15:8];
        end
        s1_prod_next = PROD_W'(s1_sa_next) * PROD_W'(opac_reg);
    end

    always_ff @(posedge clk)
    begin
        s1_sr_reg    <= s1_sr_next;
        s1_sg_reg    <= s1_sg_next;
        s1_sb_reg    <= s1_sb_next;
        s1_sa_reg    <= s1_sa_next;
        s1_prod_reg  <= s1_prod_next;
        s1_scale_reg <= opac_reg < OPAC_FULL;
        s1_dr_reg    <= dest_red;
        s1_dg_reg    <= dest_green;
        s1_db_reg    <= dest_blue;
        s1_da_reg    <= dest_alpha;
    end

    // stage 2: opacity scaling
    assign s2_alpha_next = s1_scale_reg ? div100(s1_prod_reg) : s1_sa_reg;

    always_ff @(posedge clk)
    begin
        s2_alpha_reg <= s2_alpha_next;
        s2_sr_reg    <= s1_sr_reg;
        s2_sg_reg    <= s1_sg_reg;
        s2_sb_reg    <= s1_sb_reg;
        s2_dr_reg    <= s1_dr_reg;
        s2_dg_reg    <= s1_dg_reg;
        s2_db_reg    <= s1_db_reg;
        s2_da_reg    <= s1_da_reg;
    end

    // stage 3: 8x8 products and the over denominator
    assign s3_inv      = CH_MAX - s2_alpha_reg;
    assign s3_src      = {s2_alpha_reg, 8'b0} - DEN_W'(s2_alpha_reg);
    assign s3_den_next = s3_src + DEN_W'(s2_da_reg) * DEN_W'(s3_inv);

    always_comb
    begin
        if (s2_alpha_reg == '0)
            s3_mode_next = MODE_KEEP;
        else if (s2_da_reg == CH_MAX)
            s3_mode_next = MODE_OPAQUE;
        else if (s2_da_reg == '0)
            s3_mode_next = MODE_CLEAR;
        else
            s3_mode_next = MODE_OVER;
    end

    always_ff @(posedge clk)
    begin
        s3_mode_reg   <= s3_mode_next;
        s3_den_reg    <= s3_den_next;
        s3_sa_r_reg   <= DEN_W'(s2_sr_reg) * DEN_W'(s2_alpha_reg);
        s3_sa_g_reg   <= DEN_W'(s2_sg_reg) * DEN_W'(s2_alpha_reg);
        s3_sa_b_reg   <= DEN_W'(s2_sb_reg) * DEN_W'(s2_alpha_reg);
        s3_dinv_r_reg <= DEN_W'(s2_dr_reg) * DEN_W'(s3_inv);
        s3_dinv_g_reg <= DEN_W'(s2_dg_reg) * DEN_W'(s3_inv);
        s3_dinv_b_reg <= DEN_W'(s2_db_reg) * DEN_W'(s3_inv);
        s3_sr_reg     <= s2_sr_reg;
        s3_sg_reg     <= s2_sg_reg;
        s3_sb_reg     <= s2_sb_reg;
        s3_alpha_reg  <= s2_alpha_reg;
        s3_dr_reg     <= s2_dr_reg;
        s3_dg_reg     <= s2_dg_reg;
        s3_db_reg     <= s2_db_reg;
        s3_da_reg     <= s2_da_reg;
    end

    // stage 4: over numerator s*255a + d*da*(255-a) + den/2, opaque d*(255-a) + s*a
    assign s4_nov_r_next = ({s3_sa_r_reg, 8'b0} - NUM_W'(s3_sa_r_reg))
                         + NUM_W'(s3_dinv_r_reg) * NUM_W'(s3_da_reg)
                         + NUM_W'(s3_den_reg >> 1);
    assign s4_nov_g_next = ({s3_sa_g_reg, 8'b0} - NUM_W'(s3_sa_g_reg))
                         + NUM_W'(s3_dinv_g_reg) * NUM_W'(s3_da_reg)
                         + NUM_W'(s3_den_reg >> 1);
    assign s4_nov_b_next = ({s3_sa_b_reg, 8'b0} - NUM_W'(s3_sa_b_reg))
                         + NUM_W'(s3_dinv_b_reg) * NUM_W'(s3_da_reg)
                         + NUM_W'(s3_den_reg >> 1);

    always_ff @(posedge clk)
    begin
        s4_mode_reg  <= s3_mode_reg;
        s4_den_reg   <= s3_den_reg;
        s4_nov_r_reg <= s4_nov_r_next;
        s4_nov_g_reg <= s4_nov_g_next;
        s4_nov_b_reg <= s4_nov_b_next;
        s4_nop_r_reg <= s3_dinv_r_reg + s3_sa_r_reg;
        s4_nop_g_reg <= s3_dinv_g_reg + s3_sa_g_reg;
        s4_nop_b_reg <= s3_dinv_b_reg + s3_sa_b_reg;
        s4_anum_reg  <= s3_den_reg + ROUND_255;
        s4_sr_reg    <= s3_sr_reg;
        s4_sg_reg    <= s3_sg_reg;
        s4_sb_reg    <= s3_sb_reg;
        s4_alpha_reg <= s3_alpha_reg;
        s4_dr_reg    <= s3_dr_reg;
        s4_dg_reg    <= s3_dg_reg;
        s4_db_reg    <= s3_db_reg;
        s4_da_reg    <= s3_da_reg;
    end

    lpob_div_pipe u_div_r (.clk(clk), .num(s4_nov_r_reg), .den(s4_den_reg), .quo(quo_r));
    lpob_div_pipe u_div_g (.clk(clk), .num(s4_nov_g_reg), .den(s4_den_reg), .quo(quo_g));
    lpob_div_pipe u_div_b (.clk(clk), .num(s4_nov_b_reg), .den(s4_den_reg), .quo(quo_b));

    // everything but the over colours settles here and rides along the divider
    always_comb
    begin
        side_next.mode = s4_mode_reg;
        case (s4_mode_reg)
            MODE_KEEP:
            begin
                side_next.red   = s4_dr_reg;
                side_next.green = s4_dg_reg;
                side_next.blue  = s4_db_reg;
                side_next.alpha = s4_da_reg;
            end
            MODE_OPAQUE:
            begin
                side_next.red   = div255(s4_nop_r_reg);
                side_next.green = div255(s4_nop_g_reg);
                side_next.blue  = div255(s4_nop_b_reg);
                side_next.alpha = CH_MAX;
            end
            MODE_CLEAR:
            begin
                side_next.red   = s4_sr_reg;
                side_next.green = s4_sg_reg;
                side_next.blue  = s4_sb_reg;
                side_next.alpha = s4_alpha_reg;
            end
            default:
            begin
                side_next.red   = '0;
                side_next.green = '0;
                side_next.blue  = '0;
                side_next.alpha = div255(s4_anum_reg);
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= side_next;
        for (int k = 1; k < DIV_STAGES; k++)
        begin
            side_reg[k] <= side_reg[k-1];
        end
    end

    // valid bits of every stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            for (int k = 0; k < DIV_STAGES; k++)
            begin
                side_vld_reg[k] <= 1'b0;
            end
            strobe_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg      <= accept;
            s2_vld_reg      <= s1_vld_reg;
            s3_vld_reg      <= s2_vld_reg;
            s4_vld_reg      <= s3_vld_reg;
            side_vld_reg[0] <= s4_vld_reg;
            for (int k = 1; k < DIV_STAGES; k++)
            begin
                side_vld_reg[k] <= side_vld_reg[k-1];
            end
            strobe_reg <= side_vld_reg[DIV_STAGES-1];
        end
    end

    always_comb
    begin
        if (side_reg[DIV_STAGES-1].mode == MODE_OVER)
        begin
            out_r_next = quo_r;
            out_g_next = quo_g;
            out_b_next = quo_b;
        end
        else
        begin
            out_r_next = side_reg[DIV_STAGES-1].red;
            out_g_next = side_reg[DIV_STAGES-1].green;
            out_b_next = side_reg[DIV_STAGES-1].blue;
        end
    end

    always_ff @(posedge clk)
    begin
        out_r_reg <= out_r_next;
        out_g_reg <= out_g_next;
        out_b_reg <= out_b_next;
        out_a_reg <= side_reg[DIV_STAGES-1].alpha;
    end

    assign strobe    = strobe_reg;
    assign out_red   = out_r_reg;
    assign out_green = out_g_reg;
    assign out_blue  = out_b_reg;
    assign out_alpha = out_a_reg;

`include "layer_pixel_over_blend_assert.svh"

    `LPOB_ASSERT_IMP(a_req_to_strobe, accept, ##PIPE_LATENCY strobe, "request lost in pipeline")
    `LPOB_ASSERT_NXT(a_zero_alpha_keeps, s2_vld_reg && s2_alpha_reg == '0,
        s3_mode_reg == MODE_KEEP, "zero alpha not routed to keep")
    `LPOB_ASSERT_NXT(a_opaque_alpha, s4_vld_reg && s4_mode_reg == MODE_OPAQUE,
        side_reg[0].alpha == CH_MAX, "opaque destination lost full alpha")
    `LPOB_ASSERT_IMP(a_over_den, s4_vld_reg && s4_mode_reg == MODE_OVER,
        s4_den_reg >= DEN_W'(CH_MAX), "over denominator below 255")

endmodule

### test/layer_pixel_over_blend_tb.sv
// self-checking testbench for layer_pixel_over_blend: directed corners, then random pixels
// over several opacity and byte order settings, every result checked against a local model
// depends on lpob_pkg and the layer_pixel_over_blend rtl
module layer_pixel_over_blend_tb
    import lpob_pkg::*;
;

    localparam int NUM_PHASES      = 9;
    localparam int ITEMS_PER_PHASE = 160;
    localparam int RUN_LIMIT       = 2000000;
    localparam int REG_COUNT       = 2;
    localparam int REG_INDEX_MAX   = 2**CFG_IDX_W - 1;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] alpha;
    } rgba_t;

    class composite_tracker;
        logic [OPAC_W-1:0] opacity;
        logic              big_order;
        rgba_t             pending_pixels[$];
        int                errors;
        int                checked;
        int                path_hits[4];

        function new();
            opacity   = OPAC_FULL;
            big_order = 1'b0;
            errors    = 0;
            checked   = 0;
            foreach (path_hits[i]) path_hits[i] = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_LAYER_OPACITY)
                opacity = data[OPAC_W-1:0];
            else if (idx == REG_BYTE_ORDER_BIG)
                big_order = data[0];
        endfunction

        function rgba_t composite(logic [PIX_W-1:0] word, rgba_t dest);
            int         s[3];
            int         d[3];
            int         o[3];
            int         a;
            int         src;
            int         dst;
            int         den;
            int         full;
            lpob_mode_t path;
            rgba_t      res;
            full = int'(CH_MAX);
            if (big_order) begin
                s[0] = word[7:0];
                s[1] = word[23:16];
                s[2] = word[39:32];
                a    = word[55:48];
            end
            else begin
                s[0] = word[63:56];
                s[1] = word[47:40];
                s[2] = word[31:24];
                a    = word[15:8];
            end
            d[0] = dest.red;
            d[1] = dest.green;
            d[2] = dest.blue;
            // opacity values above full strength leave alpha alone
            if (opacity < OPAC_FULL)
                a = a * int'(opacity) / int'(OPAC_FULL);
            res = dest;
            if (a == 0) begin
                path = MODE_KEEP;
            end
            else if (dest.alpha == CH_MAX) begin
                path = MODE_OPAQUE;
                for (int i = 0; i < 3; i++)
                    o[i] = (full * d[i] - (d[i] - s[i]) * a) / full;
                res = {8'(o[0]), 8'(o[1]), 8'(o[2]), CH_MAX};
            end
            else if (dest.alpha == 0) begin
                path = MODE_CLEAR;
                res = {8'(s[0]), 8'(s[1]), 8'(s[2]), 8'(a)};
            end
            else begin
                path = MODE_OVER;
                src = a * full;
                dst = int'(dest.alpha) * (full - a);
                den = src + dst;
                for (int i = 0; i < 3; i++)
                    o[i] = (s[i] * src + d[i] * dst + den / 2) / den;
                res = {8'(o[0]), 8'(o[1]), 8'(o[2]), 8'((den + int'(ROUND_255)) / full)};
            end
            path_hits[int'(path)]++;
            return res;
        endfunction

        function void note_request(logic [PIX_W-1:0] word, rgba_t dest);
            pending_pixels.push_back(composite(word, dest));
        endfunction

        function void check_channel(string name, logic [CH_W-1:0] exp, logic [CH_W-1:0] act);
            if (exp !== act) begin
                $error("%s mismatch: expected %0d, got %0d", name, exp, act);
                errors++;
            end
        endfunction

        function void check_result(rgba_t got);
            rgba_t exp;
            if (pending_pixels.size() == 0) begin
                $error("result strobe with no request outstanding");
                errors++;
                return;
            end
            exp = pending_pixels.pop_front();
            check_channel("out_red", exp.red, got.red);
            check_channel("out_green", exp.green, got.green);
            check_channel("out_blue", exp.blue, got.blue);
            check_channel("out_alpha", exp.alpha, got.alpha);
            checked++;
        endfunction

        function int pending();
            return pending_pixels.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [PIX_W-1:0]      pixel_word;
    logic [CH_W-1:0]       dest_red;
    logic [CH_W-1:0]       dest_green;
    logic [CH_W-1:0]       dest_blue;
    logic [CH_W-1:0]       dest_alpha;
    logic                  strobe;
    logic [CH_W-1:0]       out_red;
    logic [CH_W-1:0]       out_green;
    logic [CH_W-1:0]       out_blue;
    logic [CH_W-1:0]       out_alpha;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    composite_tracker tracker;
    int               settings_run;

    layer_pixel_over_blend uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .pixel_word (pixel_word),
        .dest_red   (dest_red),
        .dest_green (dest_green),
        .dest_blue  (dest_blue),
        .dest_alpha (dest_alpha),
        .strobe     (strobe),
        .out_red    (out_red),
        .out_green  (out_green),
        .out_blue   (out_blue),
        .out_alpha  (out_alpha),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // sampled at the rising edge, inputs only move on the falling edge
    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_valid && cfg_ready)
                tracker.write_reg(cfg_index, cfg_data);
            if (start && !busy)
                tracker.note_request(pixel_word,
                                     {dest_red, dest_green, dest_blue, dest_alpha});
            if (strobe)
                tracker.check_result({out_red, out_green, out_blue, out_alpha});
        end
    end

    // called at a falling edge, returns at the falling edge after the request is taken
    task automatic send_pixel(int gap, logic [PIX_W-1:0] word, rgba_t dest);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start      <= 1'b1;
        pixel_word <= word;
        dest_red   <= dest.red;
        dest_green <= dest.green;
        dest_blue  <= dest.blue;
        dest_alpha <= dest.alpha;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (tracker.pending() != 0)
            @(negedge clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic set_config(int opac, bit big);
        drain_results();
        cfg_write(REG_LAYER_OPACITY, 7'(opac));
        // only bit 0 of the byte order register matters
        cfg_write(REG_BYTE_ORDER_BIG, {6'($urandom), big});
        if ($urandom_range(0, 2) == 0)
            cfg_write(4'($urandom_range(REG_COUNT, REG_INDEX_MAX)), 7'($urandom));
        cfg_valid <= 1'b0;
        settings_run++;
    endtask

    function automatic logic [PIX_W-1:0] pack_pixel(logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                                                     logic [CH_W-1:0] b, logic [CH_W-1:0] a);
        logic [PIX_W-1:0] w;
        w = {$urandom, $urandom};
        if (tracker.big_order) begin
            w[7:0]   = r;
            w[23:16] = g;
            w[39:32] = b;
            w[55:48] = a;
        end
        else begin
            w[63:56] = r;
            w[47:40] = g;
            w[31:24] = b;
            w[15:8]  = a;
        end
        return w;
    endfunction

    initial begin
        tracker      = new();
        settings_run = 0;
        rst_n        = 1'b0;
        start        = 1'b0;
        pixel_word   = '0;
        dest_red     = '0;
        dest_green   = '0;
        dest_blue    = '0;
        dest_alpha   = '0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: full opacity, little-endian words
        send_pixel(0, pack_pixel(200, 100, 50, 0), {8'd10, 8'd20, 8'd30, 8'd128});
        send_pixel(0, {PIX_W{1'b0}}, {8'd255, 8'd255, 8'd255, 8'd255});
        send_pixel(0, {PIX_W{1'b1}}, {8'd0, 8'd0, 8'd0, 8'd0});
        send_pixel(1, pack_pixel(0, 255, 128, 255), {8'd255, 8'd0, 8'd128, 8'd255});
        send_pixel(0, pack_pixel(255, 0, 77, 1), {8'd0, 8'd255, 8'd77, 8'd255});
        send_pixel(0, pack_pixel(12, 34, 56, 128), {8'd99, 8'd98, 8'd97, 8'd0});
        send_pixel(2, pack_pixel(255, 255, 0, 128), {8'd0, 8'd1, 8'd255, 8'd1});
        send_pixel(0, pack_pixel(0, 128, 255, 255), {8'd255, 8'd128, 8'd0, 8'd254});
        send_pixel(0, pack_pixel(255, 0, 255, 1), {8'd0, 8'd255, 8'd0, 8'd1});
        send_pixel(0, pack_pixel(17, 240, 99, 200), {8'd201, 8'd3, 8'd150, 8'd100});

        // zero opacity keeps the destination whatever the source alpha
        set_config(0, 1'b1);
        send_pixel(0, {PIX_W{1'b1}}, {8'd1, 8'd2, 8'd3, 8'd200});
        send_pixel(0, pack_pixel(40, 50, 60, 255), {8'd70, 8'd80, 8'd90, 8'd0});

        set_config(50, 1'b1);
        send_pixel(0, pack_pixel(255, 0, 128, 255), {8'd0, 8'd255, 8'd64, 8'd255});
        send_pixel(0, pack_pixel(255, 255, 255, 1), {8'd5, 8'd6, 8'd7, 8'd77});
        send_pixel(0, pack_pixel(9, 8, 7, 3), {8'd200, 8'd201, 8'd202, 8'd0});

        // opacity above one hundred behaves as full strength
        set_config(127, 1'b0);
        send_pixel(0, pack_pixel(255, 1, 127, 255), {8'd0, 8'd254, 8'd128, 8'd128});
        send_pixel(0, pack_pixel(33, 66, 99, 100), {8'd250, 8'd125, 8'd60, 8'd255});

        set_config(99, 1'b0);
        send_pixel(0, pack_pixel(255, 128, 0, 255), {8'd0, 8'd128, 8'd255, 8'd50});
        send_pixel(0, pack_pixel(11, 22, 33, 101), {8'd44, 8'd55, 8'd66, 8'd0});

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            int opac;
            bit big;
            bit no_gaps;
            case (ph)
                0: begin opac = 100; big = 1'b0; end
                1: begin opac = 100; big = 1'b1; end
                2: begin opac = 0;   big = 1'b0; end
                3: begin opac = 127; big = 1'b1; end
                4: begin opac = 1;   big = 1'b0; end
                5: begin opac = 99;  big = 1'b1; end
                6: begin opac = 50;  big = 1'b1; end
                7: begin opac = $urandom_range(101, 126); big = 1'b0; end
                default: begin opac = $urandom_range(0, 127); big = 1'($urandom); end
            endcase
            set_config(opac, big);
            no_gaps = ($urandom_range(0, 2) == 0);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                logic [PIX_W-1:0] word;
                logic [CH_W-1:0]  src_alpha;
                rgba_t            dest;
                int               pick;
                int               gap;
                word      = {$urandom, $urandom};
                src_alpha = tracker.big_order ? word[55:48] : word[15:8];
                pick = $urandom_range(0, 99);
                if (pick < 10)
                    src_alpha = 8'd0;
                else if (pick < 25)
                    src_alpha = CH_MAX;
                else if (pick < 30)
                    src_alpha = 8'd1;
                if (tracker.big_order)
                    word[55:48] = src_alpha;
                else
                    word[15:8] = src_alpha;
                dest = $urandom;
                pick = $urandom_range(0, 99);
                if (pick < 15)
                    dest.alpha = 8'd0;
                else if (pick < 35)
                    dest.alpha = CH_MAX;
                else if (pick < 40)
                    dest.alpha = 8'd1;
                else if (pick < 45)
                    dest.alpha = 8'd254;
                // mostly back to back, some short gaps, a few long ones
                pick = $urandom_range(0, 99);
                if (no_gaps || pick < 60)
                    gap = 0;
                else if (pick < 90)
                    gap = $urandom_range(1, 3);
                else if (pick < 97)
                    gap = $urandom_range(4, 8);
                else
                    gap = $urandom_range(10, 40);
                send_pixel(gap, word, dest);
            end
        end

        drain_results();
        repeat (PIPE_LATENCY + 4) @(negedge clk);
        $display("checked %0d blended pixels over %0d register settings",
                 tracker.checked, settings_run);
        $display("paths taken: keep %0d, opaque %0d, clear %0d, over %0d",
                 tracker.path_hits[int'(MODE_KEEP)], tracker.path_hits[int'(MODE_OPAQUE)],
                 tracker.path_hits[int'(MODE_CLEAR)], tracker.path_hits[int'(MODE_OVER)]);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("layer_pixel_over_blend_tb passed");
        else
            $display("layer_pixel_over_blend_tb failed");
        $finish;
    end

    initial begin
        #(RUN_LIMIT);
        $display("timeout waiting for requests or results");
        $display("layer_pixel_over_blend_tb failed");
        $finish;
    end

endmodule
